// ----- sv/stid_pkg.sv -----
package stid_pkg;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 20;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 10;
  localparam int STEP_W   = 4;

  localparam logic [KEY_W-1:0] KEY_LIMIT = KEY_W'(999999);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ORDER     = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key_value;
  } in_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  entry_index;
    logic [KEY_W-1:0]    key_out;
  } out_res_t;

  // Datapath operations selected by the control word.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_APPEND,
    OP_PROBE,
    OP_NARROW,
    OP_HIT,
    OP_MISS,
    OP_EMIT
  } op_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_IN_REQ,
    C_CMD_BAD,
    C_CMD_LOOKUP,
    C_LO_GE_HI,
    C_PROBE_NE,
    C_OUT_FREE
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_IDLE   = 4'd0;
  localparam step_t S_DECODE = 4'd1;
  localparam step_t S_ROUTE  = 4'd2;
  localparam step_t S_APPEND = 4'd3;
  localparam step_t S_PROBE  = 4'd4;
  localparam step_t S_NARROW = 4'd5;
  localparam step_t S_HIT    = 4'd6;
  localparam step_t S_MISS   = 4'd7;
  localparam step_t S_EMIT   = 4'd8;

  // When cond is true the step counter loads tgt; otherwise it holds
  // (hold set) or advances by one.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  hold;
    step_t tgt;
  } ucode_t;

  // Control and status between sequencer and datapath.
  typedef struct packed {
    op_t  op;
  } dp_ctrl_t;

  typedef struct packed {
    logic cmd_bad;
    logic cmd_lookup;
    logic lo_ge_hi;
    logic probe_ne;
  } dp_flags_t;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    unique case (s)
      S_IDLE:   w = '{op: OP_CAPTURE, cond: C_IN_REQ,     hold: 1'b1, tgt: S_DECODE};
      S_DECODE: w = '{op: OP_NOP,     cond: C_CMD_BAD,    hold: 1'b0, tgt: S_IDLE};
      S_ROUTE:  w = '{op: OP_NOP,     cond: C_CMD_LOOKUP, hold: 1'b0, tgt: S_PROBE};
      S_APPEND: w = '{op: OP_APPEND,  cond: C_ALWAYS,     hold: 1'b0, tgt: S_EMIT};
      S_PROBE:  w = '{op: OP_PROBE,   cond: C_LO_GE_HI,   hold: 1'b0, tgt: S_MISS};
      S_NARROW: w = '{op: OP_NARROW,  cond: C_PROBE_NE,   hold: 1'b0, tgt: S_PROBE};
      S_HIT:    w = '{op: OP_HIT,     cond: C_ALWAYS,     hold: 1'b0, tgt: S_EMIT};
      S_MISS:   w = '{op: OP_MISS,    cond: C_NEVER,      hold: 1'b0, tgt: S_EMIT};
      S_EMIT:   w = '{op: OP_EMIT,    cond: C_OUT_FREE,   hold: 1'b1, tgt: S_IDLE};
      default:  w = '{op: OP_NOP,     cond: C_ALWAYS,     hold: 1'b0, tgt: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- sv/stid_seq.sv -----
module stid_seq
  import stid_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_free,
  input  dp_flags_t flags,
  output dp_ctrl_t  ctrl,
  output logic      busy
);

  step_t  step_r;
  step_t  step_nxt;
  ucode_t word;
  logic   cond_hit;

  assign word = ucode_rom(step_r);

  always_comb begin
    unique case (word.cond)
      C_NEVER:      cond_hit = 1'b0;
      C_ALWAYS:     cond_hit = 1'b1;
      C_IN_REQ:     cond_hit = in_valid;
      C_CMD_BAD:    cond_hit = flags.cmd_bad;
      C_CMD_LOOKUP: cond_hit = flags.cmd_lookup;
      C_LO_GE_HI:   cond_hit = flags.lo_ge_hi;
      C_PROBE_NE:   cond_hit = flags.probe_ne;
      C_OUT_FREE:   cond_hit = out_free;
      default:      cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    priority if (cond_hit) begin
      step_nxt = word.tgt;
    end else if (word.hold) begin
      step_nxt = step_r;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign ctrl.op = word.op;
  assign busy    = (step_r != S_IDLE);

endmodule

// ----- sv/stid_dp.sv -----
module stid_dp
  import stid_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_req_t   in_data,
  input  dp_ctrl_t  ctrl,
  output dp_flags_t flags,
  output out_res_t  res
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = $clog2(TABLE_DEPTH);

  logic [KEY_W-1:0] mem [TABLE_DEPTH];

  logic [CMD_W-1:0] cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [CW-1:0]    count_r;
  logic [KEY_W-1:0] last_key_r;
  logic [CW-1:0]    lo_r;
  logic [CW-1:0]    hi_r;
  logic [CW-1:0]    mid_r;
  logic [KEY_W-1:0] rdata_r;
  out_res_t         res_r;

  logic [CW-1:0]       mid_nxt;
  logic [KEY_W:0]      next_key;
  logic                full;
  logic                empty;
  logic [STATUS_W-1:0] app_status;
  logic                app_ok;
  logic [KEY_W-1:0]    app_key;

  function automatic logic [INDEX_W-1:0] to_index(input logic [CW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[INDEX_W-1:0];
  endfunction

  assign full     = (count_r == CW'(TABLE_DEPTH));
  assign empty    = (count_r == '0);
  assign next_key = {1'b0, last_key_r} + 1'b1;
  // Lower middle of the half-open range [lo, hi).
  assign mid_nxt  = lo_r + ((hi_r - 1'b1 - lo_r) >> 1);

  always_comb begin
    app_status = ST_OK;
    app_ok     = 1'b0;
    app_key    = key_r;
    if (cmd_r == CMD_LOAD) begin
      priority if (full) begin
        app_status = ST_FULL;
      end else if (key_r > KEY_LIMIT) begin
        app_status = ST_OVERFLOW;
      end else if (!empty && key_r <= last_key_r) begin
        app_status = ST_ORDER;
      end else begin
        app_ok = 1'b1;
      end
    end else begin
      app_key = next_key[KEY_W-1:0];
      priority if (empty) begin
        app_status = ST_EMPTY;
      end else if (full) begin
        app_status = ST_FULL;
      end else if (next_key > {1'b0, KEY_LIMIT}) begin
        app_status = ST_OVERFLOW;
      end else begin
        app_ok = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.op == OP_APPEND && app_ok) begin
      count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_APPEND && app_ok) begin
      mem[count_r[AW-1:0]] <= app_key;
    end
    if (ctrl.op == OP_PROBE) begin
      rdata_r <= mem[mid_nxt[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_CAPTURE: begin
        cmd_r <= in_data.command;
        key_r <= in_data.key_value;
        lo_r  <= '0;
        hi_r  <= count_r;
      end
      OP_APPEND: begin
        if (app_ok) begin
          last_key_r <= app_key;
          res_r      <= '{status: ST_OK, entry_index: to_index(count_r), key_out: app_key};
        end else begin
          res_r <= '{status: app_status, entry_index: '0, key_out: '0};
        end
      end
      OP_PROBE: begin
        mid_r <= mid_nxt;
      end
      OP_NARROW: begin
        if (rdata_r > key_r) begin
          hi_r <= mid_r;
        end else begin
          lo_r <= mid_r + 1'b1;
        end
      end
      OP_HIT: begin
        res_r <= '{status: ST_OK, entry_index: to_index(mid_r), key_out: rdata_r};
      end
      OP_MISS: begin
        res_r <= '{status: ST_NOT_FOUND, entry_index: '0, key_out: '0};
      end
      default: begin
      end
    endcase
  end

  assign flags.cmd_bad    = (cmd_r != CMD_LOAD) && (cmd_r != CMD_ADD) && (cmd_r != CMD_LOOKUP);
  assign flags.cmd_lookup = (cmd_r == CMD_LOOKUP);
  assign flags.lo_ge_hi   = (lo_r >= hi_r);
  assign flags.probe_ne   = (rdata_r != key_r);
  assign res              = res_r;

endmodule

// ----- sv/sorted_id_table_search_unit.sv -----
// Sorted key table with append and binary-search lookup.
// Input channel (in_valid, in_stall, in_data): one request carries a command
// and a key. Load appends the key if it exceeds the last key held, add
// appends the last key plus one, lookup searches the held keys. An unused
// command code is dropped without a result.
// Result channel (out_valid, out_stall, out_data): one result per carried-out
// request, with a status, the entry index and the key.
// A small control program steps through a plain datapath one request at a
// time; in_stall is high from acceptance until the result is loaded into the
// output register. Load and add step through decode, route, append and emit.
// Lookup steps through decode and route, then makes p probes, where p is at
// most ceil(log2(entries + 1)), and ends in hit or miss, then emit. Each probe
// takes two steps: probe reads the single-port key memory, then narrow
// compares the registered word.
// A new request is accepted while a result waits in the output register; if
// the receiver stalls, the next result holds in its last step until taken.
// Reset empties the table (key memory contents are not cleared) and drops
// any result in flight.
module sorted_id_table_search_unit
  import stid_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_data
);

  dp_ctrl_t  ctrl;
  dp_flags_t flags;
  out_res_t  res;
  logic      busy;
  logic      out_free;
  logic      emit;
  logic      out_valid_r;
  out_res_t  out_data_r;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = (ctrl.op == OP_EMIT) && out_free;

  stid_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .flags    (flags),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  stid_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .ctrl    (ctrl),
    .flags   (flags),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= res;
    end
  end

  assign in_stall  = busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // An accepted request keeps the sequencer busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted but sequencer not busy");

  // A failed command carries neither index nor key.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |->
      (out_data.entry_index == '0 && out_data.key_out == '0))
    else $error("failed result carries index or key");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= ST_ORDER))
    else $error("undefined status code");

  // A result is only loaded once the previous one has left.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result lost or changed");
`endif

endmodule
